// ----- rtl/core/ehist_pkg.sv -----
`timescale 1ns / 1ps
package ehist_pkg;

	// Default sizing of the stores.
	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int MAX_BINS_DEF    = 16;
	localparam int MAX_SETS_DEF    = 4;

	// Configuration register indexes and reset values.
	localparam logic REG_N_BINS = 1'b0;
	localparam logic REG_N_SETS = 1'b1;
	localparam logic [4:0] N_BINS_RST = 5'd16;
	localparam logic [2:0] N_SETS_RST = 3'd1;

	// One unit in Q16.16, used when the range is empty.
	localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

	// Edges are kept at 35 bits: min plus a span of up to 2^32.
	localparam int EDGE_W = 35;

	typedef struct packed {
		logic signed [31:0] sample;
		logic [1:0]         set_index;
		logic               last_sample;
	} in_t;

	typedef struct packed {
		logic [1:0]         out_set;
		logic [3:0]         bin_index;
		logic signed [31:0] bin_left;
		logic signed [31:0] bin_right;
		logic [10:0]        bin_count;
		logic               dropped_flag;
		logic               last_result;
	} out_t;

	// Saturate a wide edge value to 32 signed bits.
	function automatic logic signed [31:0] sat32(input logic signed [EDGE_W-1:0] v);
		logic signed [31:0] r;
		if (v > $signed({{(EDGE_W-32){1'b0}}, 32'h7FFFFFFF})) begin
			r = 32'sh7FFFFFFF;
		end else if (v < $signed({{(EDGE_W-32){1'b1}}, 32'h80000000})) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/ehist_ram.sv -----
`timescale 1ns / 1ps
module ehist_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/ehist_div.sv -----
`timescale 1ns / 1ps
module ehist_div #(
	parameter int DW = 38,
	parameter int VW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fits;

	// Restoring division, one quotient bit per cycle.
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and the dividend that shifts into the quotient.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(trial - {1'b0, dsr_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/core/equal_width_histogram_core.sv -----
`timescale 1ns / 1ps
// Equal-width histogram over a batch of Q16.16 samples.
// Input channel in_valid/in_ready/in_data carries one sample with its data
// set and a last_sample mark. Samples are stored one per cycle while the
// block collects a batch; the running minimum and maximum follow along.
// A transfer with last_sample set ends the batch: in_ready drops and the
// block forms n_bins right edges with a shared serial divider, one bin
// after another, then walks the sample store, searching the edges one
// per cycle for each stored sample.
// Results leave on out_valid/out_ready/out_data, one transfer per
// (set, bin), sets ascending and bins ascending. A stalled receiver
// holds the output register and the walk waits; in_ready returns after
// the last result is loaded into the output register.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written while
// idle; the block itself does not enforce it.
// Reset clears the batch state and the count store valid bits at once;
// there is no clearing pass. The sample store holds MAX_SAMPLES entries,
// further samples are dropped and reported in dropped_flag.
module equal_width_histogram_core
	import ehist_pkg::*;
#(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int MAX_BINS    = MAX_BINS_DEF,
	parameter int MAX_SETS    = MAX_SETS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [4:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data
);

	localparam int SAW = $clog2(MAX_SAMPLES);
	localparam int CNW = $clog2(MAX_SAMPLES + 1);
	localparam int NBW = $clog2(MAX_BINS + 1);
	localparam int BAW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CDEPTH = MAX_SETS * MAX_BINS;
	localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int PW  = 34 + NBW;

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_DIVGO = 4'd2;
	localparam logic [3:0] S_DIVW  = 4'd3;
	localparam logic [3:0] S_BRD   = 4'd4;
	localparam logic [3:0] S_BTAG  = 4'd5;
	localparam logic [3:0] S_BCMP  = 4'd6;
	localparam logic [3:0] S_BINC  = 4'd7;
	localparam logic [3:0] S_ORD   = 4'd8;
	localparam logic [3:0] S_OLD   = 4'd9;

	logic [3:0] state_q;
	logic [4:0] nbins_q;
	logic [2:0] nsets_q;
	logic [NBW-1:0] nb;
	logic [2:0] ns;

	logic [CNW-1:0] cnt_q;
	logic [CNW-1:0] idx_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic ovf_q;
	logic [32:0] span_q;
	logic [PW-1:0] prod_q;
	logic [NBW-1:0] bin_q;
	logic [2:0] set_q;
	logic signed [31:0] v_q;
	logic [1:0] tag_q;
	logic signed [EDGE_W-1:0] prev_right_q;

	logic out_valid_q;
	out_t out_q;

	// Clamped register values.
	always_comb begin
		if (nbins_q == 5'd0) begin
			nb = NBW'(1);
		end else if (int'(nbins_q) > MAX_BINS) begin
			nb = NBW'(MAX_BINS);
		end else begin
			nb = NBW'(nbins_q);
		end
		if (nsets_q == 3'd0) begin
			ns = 3'd1;
		end else if (int'(nsets_q) > MAX_SETS) begin
			ns = 3'(MAX_SETS);
		end else begin
			ns = nsets_q;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbins_q <= N_BINS_RST;
			nsets_q <= N_SETS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_N_BINS: nbins_q <= cfg_data;
				REG_N_SETS: nsets_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	logic in_xfer;
	logic set_ok;
	logic store_ok;
	assign in_ready = (state_q == S_LOAD);
	assign in_xfer  = in_valid && in_ready;
	assign set_ok   = ({1'b0, in_data.set_index} < ns);
	assign store_ok = set_ok && (cnt_q < CNW'(MAX_SAMPLES));

	// Sample store: value and set tag side by side.
	logic [33:0] smp_rdata;
	logic        smp_re;
	ehist_ram #(.WIDTH(34), .DEPTH(MAX_SAMPLES)) u_smp_ram (
		.clk   (clk),
		.we    (in_xfer && store_ok),
		.waddr (cnt_q[SAW-1:0]),
		.wdata ({in_data.sample, in_data.set_index}),
		.re    (smp_re),
		.raddr (idx_q[SAW-1:0]),
		.rdata (smp_rdata)
	);

	// Shared divider for the bin edges.
	logic          div_start;
	logic          div_busy;
	logic          div_done;
	logic [PW-1:0] div_q;
	ehist_div #(.DW(PW), .VW(NBW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (nb),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	// Right edge store.
	logic signed [EDGE_W-1:0] edge_new;
	logic [EDGE_W-1:0] edge_rdata;
	logic              edge_re;
	logic [BAW-1:0]    edge_raddr;
	assign edge_new = $signed({{(EDGE_W-32){min_q[31]}}, min_q})
		+ $signed({1'b0, div_q[EDGE_W-2:0]});
	ehist_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_BINS)) u_edge_ram (
		.clk   (clk),
		.we    (state_q == S_DIVW && div_done),
		.waddr (bin_q[BAW-1:0]),
		.wdata (edge_new),
		.re    (edge_re),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	// Count store with a valid bit per entry; invalid entries read as zero.
	logic [10:0]     cnt_rdata;
	logic            cnt_re;
	logic            cnt_we;
	logic [CAW-1:0]  cnt_raddr;
	logic [CAW-1:0]  cnt_waddr_q;
	logic [CDEPTH-1:0] cvld_q;
	logic            cvld_rd_q;
	logic [10:0]     cnt_cur;
	logic [1:0]      cnt_set;

	assign cnt_set   = (state_q == S_BCMP) ? tag_q : set_q[1:0];
	assign cnt_raddr = CAW'(int'(cnt_set) * MAX_BINS + int'(bin_q));
	assign cnt_cur   = cvld_rd_q ? cnt_rdata : 11'd0;
	assign cnt_we    = (state_q == S_BINC);
	ehist_ram #(.WIDTH(11), .DEPTH(CDEPTH)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr_q),
		.wdata ((cnt_cur == 11'h7FF) ? cnt_cur : cnt_cur + 11'd1),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	logic edge_hit;
	logic last_bin;
	logic last_entry;
	logic out_free;
	assign edge_hit   = ($signed({{(EDGE_W-32){v_q[31]}}, v_q}) <= $signed(edge_rdata));
	assign last_bin   = (bin_q == nb - 1'b1);
	assign last_entry = last_bin && (set_q == ns - 3'd1);
	assign out_free   = !out_valid_q || out_ready;

	// Read requests issued by the sequencer.
	always_comb begin
		smp_re     = (state_q == S_BRD);
		edge_re    = 1'b0;
		edge_raddr = bin_q[BAW-1:0];
		cnt_re     = 1'b0;
		div_start  = (state_q == S_DIVGO);
		case (state_q)
			S_BTAG: begin
				edge_re    = 1'b1;
				edge_raddr = '0;
			end
			S_BCMP: begin
				edge_re    = !edge_hit && !last_bin;
				edge_raddr = BAW'(bin_q + 1'b1);
				cnt_re     = edge_hit;
			end
			S_ORD: begin
				edge_re = 1'b1;
				cnt_re  = 1'b1;
			end
			default: ;
		endcase
	end

	// Valid bits of the count store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_q    <= '0;
			cvld_rd_q <= 1'b0;
		end else begin
			if (cnt_re) begin
				cvld_rd_q <= cvld_q[cnt_raddr];
			end
			if (state_q == S_OLD && out_free && last_entry) begin
				cvld_q <= '0;
			end else if (cnt_we) begin
				cvld_q[cnt_waddr_q] <= 1'b1;
			end
		end
	end

	// Output valid: set when an entry is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and batch state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			bin_q       <= '0;
			set_q       <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						if (store_ok) begin
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q == '0 || in_data.sample < min_q) begin
								min_q <= in_data.sample;
							end
							if (cnt_q == '0 || in_data.sample > max_q) begin
								max_q <= in_data.sample;
							end
						end else if (set_ok) begin
							ovf_q <= 1'b1;
						end
						if (in_data.last_sample) begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					bin_q   <= '0;
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						if (last_bin) begin
							idx_q   <= '0;
							bin_q   <= '0;
							set_q   <= '0;
							state_q <= (cnt_q == '0) ? S_ORD : S_BRD;
						end else begin
							bin_q   <= bin_q + 1'b1;
							state_q <= S_DIVGO;
						end
					end
				end
				S_BRD: begin
					state_q <= S_BTAG;
				end
				S_BTAG: begin
					bin_q <= '0;
					if ({1'b0, smp_rdata[1:0]} < ns) begin
						state_q <= S_BCMP;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= (idx_q + 1'b1 == cnt_q) ? S_ORD : S_BRD;
					end
				end
				S_BCMP: begin
					if (edge_hit) begin
						state_q <= S_BINC;
					end else if (last_bin) begin
						idx_q   <= idx_q + 1'b1;
						bin_q   <= '0;
						state_q <= (idx_q + 1'b1 == cnt_q) ? S_ORD : S_BRD;
					end else begin
						bin_q <= bin_q + 1'b1;
					end
				end
				S_BINC: begin
					idx_q   <= idx_q + 1'b1;
					bin_q   <= '0;
					state_q <= (idx_q + 1'b1 == cnt_q) ? S_ORD : S_BRD;
				end
				S_ORD: begin
					state_q <= S_OLD;
				end
				S_OLD: begin
					if (out_free) begin
						if (last_entry) begin
							cnt_q   <= '0;
							min_q   <= '0;
							max_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							if (last_bin) begin
								bin_q <= '0;
								set_q <= set_q + 3'd1;
							end else begin
								bin_q <= bin_q + 1'b1;
							end
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	logic signed [32:0] hi_ext;
	assign hi_ext = (max_q <= min_q) ? ($signed({min_q[31], min_q}) + ONE_Q16)
		: $signed({max_q[31], max_q});

	always_ff @(posedge clk) begin
		case (state_q)
			S_PREP: begin
				span_q <= 33'(hi_ext - $signed({min_q[31], min_q}));
				prod_q <= PW'(33'(hi_ext - $signed({min_q[31], min_q})));
			end
			S_DIVW: begin
				if (div_done) begin
					prod_q <= prod_q + PW'(span_q);
				end
			end
			S_BTAG: begin
				v_q   <= smp_rdata[33:2];
				tag_q <= smp_rdata[1:0];
			end
			S_BCMP: begin
				cnt_waddr_q <= cnt_raddr;
			end
			S_OLD: begin
				if (out_free) begin
					out_q.out_set      <= set_q[1:0];
					out_q.bin_index    <= bin_q[3:0];
					out_q.bin_left     <= (bin_q == '0) ? min_q : sat32(prev_right_q);
					out_q.bin_right    <= sat32(edge_rdata);
					out_q.bin_count    <= cnt_cur;
					out_q.dropped_flag <= ovf_q;
					out_q.last_result  <= last_entry;
					prev_right_q       <= edge_rdata;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNW'(MAX_SAMPLES))
		else $error("stored sample count above capacity");
	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_data.last_sample) |=> !in_ready)
		else $error("input still taken after the end of a batch");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");
	a_minmax: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD && cnt_q != '0) |-> (min_q <= max_q))
		else $error("running minimum above running maximum");
	a_count_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |=> !cnt_we)
		else $error("count store written on two cycles in a row");
`endif

endmodule

// ----- test/hist_checker.sv -----
`timescale 1ns / 1ps
module hist_checker
	import ehist_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [4:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  in_t        in_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  out_t       out_data,
	output int         fail_count,
	output int         pending
);

	localparam int DEPTH = 1024;

	// Predictor state for the batch being collected.
	logic signed [31:0] held_val [DEPTH];
	logic [1:0]         held_set [DEPTH];
	int                 held_n;
	logic signed [63:0] lo_seen;
	logic signed [63:0] hi_seen;
	logic               lost;
	logic [4:0]         bins_reg;
	logic [2:0]         sets_reg;
	out_t               entry_q[$];

	assign pending = entry_q.size();

	function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Build every (set, bin) entry at the end of a batch.
	task automatic close_batch();
		int                 nb;
		int                 ns;
		logic signed [63:0] lo;
		logic signed [63:0] hi;
		logic signed [63:0] span;
		logic signed [63:0] edge_r [16];
		int                 tally [64];
		out_t               e;
		nb = (bins_reg == 0) ? 1 : (bins_reg > 16 ? 16 : bins_reg);
		ns = (sets_reg == 0) ? 1 : (sets_reg > 4 ? 4 : sets_reg);
		lo = lo_seen;
		hi = hi_seen;
		if (hi <= lo)
			hi = lo + 64'sd65536;
		span = hi - lo;
		for (int n = 0; n < nb; n++)
			edge_r[n] = lo + ((n + 1) * span) / nb;
		for (int j = 0; j < 64; j++)
			tally[j] = 0;
		for (int i = 0; i < held_n; i++) begin
			if (held_set[i] < ns) begin
				for (int n = 0; n < nb; n++) begin
					if (64'(held_val[i]) <= edge_r[n]) begin
						tally[held_set[i] * 16 + n]++;
						break;
					end
				end
			end
		end
		for (int k = 0; k < ns; k++) begin
			for (int n = 0; n < nb; n++) begin
				e.out_set      = k[1:0];
				e.bin_index    = n[3:0];
				e.bin_left     = clip32(lo + (n * span) / nb);
				e.bin_right    = clip32(edge_r[n]);
				e.bin_count    = tally[k * 16 + n] > 2047 ? 11'd2047 : 11'(tally[k * 16 + n]);
				e.dropped_flag = lost;
				e.last_result  = (k == ns - 1) && (n == nb - 1);
				entry_q = {entry_q, e};
			end
		end
		held_n = 0;
		lo_seen = 0;
		hi_seen = 0;
		lost = 0;
	endtask

	// Follow configuration writes and input transfers.
	always @(posedge clk or negedge arst_n) begin
		int ns;
		logic signed [63:0] s;
		if (!arst_n) begin
			held_n = 0;
			lo_seen = 0;
			hi_seen = 0;
			lost = 0;
			bins_reg = N_BINS_RST;
			sets_reg = N_SETS_RST;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_N_BINS)
					bins_reg = cfg_data;
				else
					sets_reg = cfg_data[2:0];
			end
			if (in_valid && in_ready) begin
				ns = (sets_reg == 0) ? 1 : (sets_reg > 4 ? 4 : sets_reg);
				s = 64'(in_data.sample);
				if (in_data.set_index < ns) begin
					if (held_n < DEPTH) begin
						if (held_n == 0 || s < lo_seen)
							lo_seen = s;
						if (held_n == 0 || s > hi_seen)
							hi_seen = s;
						held_val[held_n] = in_data.sample;
						held_set[held_n] = in_data.set_index;
						held_n++;
					end else begin
						lost = 1;
					end
				end
				if (in_data.last_sample)
					close_batch();
			end
		end
	end

	// Compare each output transfer with the oldest predicted entry.
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else if (out_valid && out_ready) begin
			if (entry_q.size() == 0) begin
				$error("unexpected output transfer %p", out_data);
				fail_count <= fail_count + 1;
			end else begin
				want = entry_q.pop_front();
				if (want !== out_data) begin
					if (want.out_set !== out_data.out_set)
						$error("out_set exp %0d got %0d", want.out_set, out_data.out_set);
					if (want.bin_index !== out_data.bin_index)
						$error("bin_index exp %0d got %0d", want.bin_index,
							out_data.bin_index);
					if (want.bin_left !== out_data.bin_left)
						$error("bin_left exp %h got %h", want.bin_left, out_data.bin_left);
					if (want.bin_right !== out_data.bin_right)
						$error("bin_right exp %h got %h", want.bin_right,
							out_data.bin_right);
					if (want.bin_count !== out_data.bin_count)
						$error("bin_count exp %0d got %0d", want.bin_count,
							out_data.bin_count);
					if (want.dropped_flag !== out_data.dropped_flag)
						$error("dropped_flag exp %b got %b", want.dropped_flag,
							out_data.dropped_flag);
					if (want.last_result !== out_data.last_result)
						$error("last_result exp %b got %b", want.last_result,
							out_data.last_result);
					fail_count <= fail_count + 1;
				end
			end
		end
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import ehist_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [4:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	in_t        in_data;
	logic       out_valid;
	logic       out_ready;
	out_t       out_data;
	int         fail_count;
	int         pending;
	int         quiet_cycles;
	logic       stim_done;

	equal_width_histogram_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	hist_checker u_check (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(0, 99) < 60 ? 0 : $urandom_range(1, 3);
	endfunction

	// Receiver side: random stalls of mixed length, some calm stretches.
	initial begin
		int g;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (g != 0) begin
				out_ready <= 0;
				repeat (g) @(negedge clk);
			end
			out_ready <= 1;
		end
	end

	// Watchdog on cycles with no transfer at all.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 200000) begin
			$display("equal_width_histogram_core: mismatch");
			$finish;
		end
	end

	// One input transfer, with an optional gap in front. Valid stays high
	// after the transfer until the next gap or an explicit drop.
	task automatic send(input logic signed [31:0] s, input logic [1:0] st,
			input logic lst);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= '{sample: s, set_index: st, last_sample: lst};
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Wait for the batch to drain, then settle before a register write.
	task automatic set_regs(input logic [4:0] nb, input logic [2:0] ns);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		while (!in_ready) @(negedge clk);
		cfg_we <= 1; cfg_index <= REG_N_BINS; cfg_data <= nb;
		@(negedge clk);
		cfg_index <= REG_N_SETS; cfg_data <= {2'b00, ns};
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 4))
			0: return 32'sh7FFFFFFF - $urandom_range(0, 3);
			1: return 32'sh80000000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 2000) - 1000;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int len;
		int ns_eff;
		arst_n = 0;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; in_data = '0;
		stim_done = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes with default registers, then an empty batch.
		send(32'sh7FFFFFFF, 2'd0, 0);
		send(32'sh80000000, 2'd0, 0);
		send(32'sh00000000, 2'd0, 1);
		send(32'sh00010000, 2'd3, 1);
		// Equal samples widen the range by one unit.
		set_regs(5'd1, 3'd4);
		send(32'sh00050000, 2'd1, 0);
		send(32'sh00050000, 2'd2, 1);
		// Registers out of range clamp; sets shrink mid batch.
		set_regs(5'd31, 3'd7);
		send(-32'sd300, 2'd3, 0);
		send(32'sd77, 2'd2, 0);
		send(32'sd1000, 2'd0, 0);
		send(32'sd5, 2'd1, 0);
		in_valid <= 0;
		cfg_we <= 1; cfg_index <= REG_N_SETS; cfg_data <= 5'd2;
		@(negedge clk);
		cfg_we <= 0;
		send(32'sd400, 2'd1, 1);
		set_regs(5'd0, 3'd0);
		send(32'sd12, 2'd0, 0);
		send(32'sd9, 2'd1, 1);

		// Random batches with varying registers.
		for (int b = 0; b < 28; b++) begin
			set_regs($urandom_range(0, 3) == 0 ? 5'd16 : 5'($urandom_range(1, 17)),
				$urandom_range(0, 3) == 0 ? 3'd4 : 3'($urandom_range(1, 5)));
			ns_eff = $urandom_range(1, 4);
			len = $urandom_range(1, 14);
			for (int i = 0; i < len; i++)
				send(rand_val(), $urandom_range(0, 9) == 0 ? 2'($urandom_range(0, 3))
					: 2'($urandom_range(0, ns_eff - 1)), i == len - 1);
		end
		in_valid <= 0;

		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("equal_width_histogram_core: match");
		else
			$display("equal_width_histogram_core: mismatch");
		$finish;
	end

endmodule
